/* src/csx_pkg.sv */
// Package: payload types and fixed constants of the CAN signal decoder.
`timescale 1ns / 1ps
`default_nettype none
package csx_pkg;

    localparam int PAYLOAD_W = 64;
    localparam int RAW_W     = 32;
    localparam int PHYS_W    = 64;
    localparam int NSEC_W    = 30;
    localparam int SEC_W     = 32;

    // remainder unit retires two quotient bits per stage, plus one output stage
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = NSEC_W / DIV_BITS_PER_STAGE;
    localparam int PIPE_DEPTH         = DIV_STAGES + 1;
    localparam int ARITH_DEPTH        = 4;

    localparam logic [5:0] MAX_LEN = 6'd32;

    // register index within the configuration map
    localparam logic REG_TIME_RES = 1'b0;

    typedef struct packed {
        logic [63:0]        payload;
        logic [5:0]         start_bit;
        logic [5:0]         bit_len;
        logic               big_endian;
        logic               is_signed;
        logic signed [31:0] scale;
        logic signed [47:0] offset;
        logic [31:0]        ts_sec;
        logic [29:0]        ts_nsec;
    } t_csx_in;

    typedef struct packed {
        logic [31:0]        raw_value;
        logic signed [63:0] physical_value;
        logic               saturated;
        logic [31:0]        out_sec;
        logic [29:0]        out_nsec;
    } t_csx_out;

    typedef struct packed {
        logic [32:0]        raw_ext;    // raw value with its numeric sign bit
        logic signed [31:0] scale;
        logic signed [47:0] offset;
    } t_csx_field;

endpackage
`default_nettype wire

/* src/csx_delay.sv */
// Enabled shift line that carries a payload a fixed number of stages.
`timescale 1ns / 1ps
`default_nettype none
module csx_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_data,
    output logic      [W-1:0] o_data
);
    logic [W-1:0] r_line [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int k = 1; k < D; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_data = r_line[D-1];
endmodule
`default_nettype wire

/* src/csx_extract.sv */
// Bit field extraction (stage 1) and sign extension (stage 2).
`timescale 1ns / 1ps
`default_nettype none
module csx_extract (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire csx_pkg::t_csx_in  i_req,
    output csx_pkg::t_csx_field    o_field
);
    import csx_pkg::*;

    logic [5:0]  n_len;
    logic [5:0]  n_sh;
    logic [63:0] n_swap;
    logic [63:0] n_word;
    logic [31:0] n_raw;
    logic [31:0] n_mask;

    logic [31:0]        r_raw;
    logic [31:0]        r_mask;
    logic [5:0]         r_len;
    logic               r_sgn;
    logic signed [31:0] r_scale;
    logic signed [47:0] r_offset;

    logic [4:0]  n_top;
    logic        n_neg;
    logic [31:0] n_ext;

    always_comb begin
        n_len = (i_req.bit_len > MAX_LEN) ? MAX_LEN : i_req.bit_len;
        n_sh  = MAX_LEN - n_len;
        // Motorola: byte-swapped word is an MSB-first bit stream
        for (int b = 0; b < 8; b++) begin
            n_swap[8*b +: 8] = i_req.payload[8*(7-b) +: 8];
        end
        if (i_req.big_endian) begin
            n_word = n_swap << {2'b00, i_req.start_bit[5:3], 3'd7 - i_req.start_bit[2:0]};
            n_raw  = n_word[63:32] >> n_sh;
        end else begin
            n_word = i_req.payload >> i_req.start_bit;
            n_raw  = n_word[31:0];
        end
        n_mask = 32'hFFFF_FFFF >> n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw    <= n_raw & n_mask;
            r_mask   <= n_mask;
            r_len    <= n_len;
            r_sgn    <= i_req.is_signed;
            r_scale  <= i_req.scale;
            r_offset <= i_req.offset;
        end
    end

    always_comb begin
        n_top = 5'(r_len - 6'd1);
        n_neg = r_sgn && (r_len != 6'd0) && (r_len != MAX_LEN) && r_raw[n_top];
        n_ext = n_neg ? (r_raw | ~r_mask) : r_raw;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_field.raw_ext <= {r_sgn & n_ext[31], n_ext};
            o_field.scale   <= r_scale;
            o_field.offset  <= r_offset;
        end
    end
endmodule
`default_nettype wire

/* src/csx_arith.sv */
// Multiply by scale (stage 3) and saturating offset add (stage 4).
`timescale 1ns / 1ps
`default_nettype none
module csx_arith (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire csx_pkg::t_csx_field  i_field,
    output logic [31:0]               o_raw,
    output logic signed [63:0]        o_phys,
    output logic                      o_sat
);
    import csx_pkg::*;

    logic signed [64:0] n_prod;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_offset;
    logic [31:0]        r_raw;
    logic signed [64:0] n_sum;

    assign n_prod = $signed(i_field.raw_ext) * i_field.scale;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod[63:0];   // product always fits 64 bits
            r_offset <= i_field.offset;
            r_raw    <= i_field.raw_ext[31:0];
        end
    end

    assign n_sum = {r_prod[63], r_prod} + {{17{r_offset[47]}}, r_offset};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_raw <= r_raw;
            if (n_sum[64] != n_sum[63]) begin
                o_phys <= n_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                o_sat  <= 1'b1;
            end else begin
                o_phys <= n_sum[63:0];
                o_sat  <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* src/csx_rem.sv */
// Pipelined restoring remainder; rounds nanoseconds down to the resolution.
`timescale 1ns / 1ps
`default_nettype none
module csx_rem (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [29:0] i_nsec,
    input  wire logic [29:0] i_res,
    output logic      [29:0] o_nsec
);
    import csx_pkg::*;

    logic [NSEC_W-1:0] r_rem  [0:DIV_STAGES-1];
    logic [NSEC_W-1:0] r_num  [0:DIV_STAGES-1];
    logic [NSEC_W-1:0] r_orig [0:DIV_STAGES-1];
    logic [NSEC_W-1:0] n_rem  [0:DIV_STAGES-1];

    function automatic logic [NSEC_W-1:0] rem_step(
        input logic [NSEC_W-1:0] rem,
        input logic              nbit,
        input logic [NSEC_W-1:0] d
    );
        logic [NSEC_W:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[NSEC_W-1:0];
    endfunction

    always_comb begin
        n_rem[0] = rem_step(rem_step('0, i_nsec[NSEC_W-1], i_res), i_nsec[NSEC_W-2], i_res);
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_rem[s] = rem_step(rem_step(r_rem[s-1], r_num[s-1][NSEC_W-1], i_res),
                                r_num[s-1][NSEC_W-2], i_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem[0];
            r_num[0]  <= i_nsec << DIV_BITS_PER_STAGE;
            r_orig[0] <= i_nsec;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_rem[s]  <= n_rem[s];
                r_num[s]  <= r_num[s-1] << DIV_BITS_PER_STAGE;
                r_orig[s] <= r_orig[s-1];
            end
            // zero resolution: pass through
            if (i_res == '0) begin
                o_nsec <= r_orig[DIV_STAGES-1];
            end else begin
                o_nsec <= r_orig[DIV_STAGES-1] - r_rem[DIV_STAGES-1];
            end
        end
    end
endmodule
`default_nettype wire

/* src/can_signal_extract_scale_core.sv */
// Top level of the CAN signal decoder: pipeline control and register port.
`timescale 1ns / 1ps
`default_nettype none
// One signal request per transfer: the signal's bit field is pulled from the
// 64-bit payload (Intel or Motorola order, bits past byte 7 read as zero),
// sign-extended when signed, and scaled as raw * scale + offset in exact
// fixed point, saturating to the signed 64-bit range. The timestamp passes
// through with nanoseconds rounded down to a multiple of time_resolution
// (register at byte address 0; 0 = no rounding). A new request is taken every
// cycle while no finished result is held; the depth of the pipeline is
// set by the remainder unit, which retires two bits of the 30-bit
// nanosecond division per stage. A stall on the result side holds the whole
// pipeline; o_in_stall is raised only while a finished result is held.
// time_resolution must only be written while no request is in flight.
module can_signal_extract_scale_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire csx_pkg::t_csx_in   i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output csx_pkg::t_csx_out       o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import csx_pkg::*;

    logic [NSEC_W-1:0]     r_time_res;
    logic [PIPE_DEPTH-1:0] r_valid;
    logic                  n_en;

    t_csx_field            w_field;
    logic [31:0]           w_raw;
    logic signed [63:0]    w_phys;
    logic                  w_sat;
    logic [32:0]           w_res_d;
    logic [31:0]           w_sec_d;
    logic [29:0]           w_nsec;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIME_RES) ? {2'b00, r_time_res} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_res <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_TIME_RES) begin
            r_time_res <= pwdata[NSEC_W-1:0];
        end
    end

    // whole pipeline advances unless a finished result is held
    assign n_en       = !(r_valid[PIPE_DEPTH-1] && i_out_stall);
    assign o_in_stall = !n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (n_en) begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    csx_extract u_extract (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_req   (i_in_data),
        .o_field (w_field)
    );

    csx_arith u_arith (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_field (w_field),
        .o_raw   (w_raw),
        .o_phys  (w_phys),
        .o_sat   (w_sat)
    );

    // value path is shorter than the remainder unit; pad it out
    csx_delay #(.W(97), .D(PIPE_DEPTH - ARITH_DEPTH)) u_val_dly (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_data ({w_raw, w_phys, w_sat}),
        .o_data ({o_out_data.raw_value, o_out_data.physical_value, o_out_data.saturated})
    );

    csx_delay #(.W(SEC_W), .D(PIPE_DEPTH)) u_sec_dly (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_data (i_in_data.ts_sec),
        .o_data (w_sec_d)
    );

    csx_rem u_rem (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_nsec (i_in_data.ts_nsec),
        .i_res  (r_time_res),
        .o_nsec (w_nsec)
    );

    assign w_res_d             = {w_sec_d, 1'b0};
    assign o_out_data.out_sec  = w_res_d[32:1];
    assign o_out_data.out_nsec = w_nsec;
    assign o_out_valid         = r_valid[PIPE_DEPTH-1];
endmodule
`default_nettype wire

/* tb/tb_can_signal_extract_scale_core.sv */
// Testbench for the CAN signal decoder: directed and random requests, with a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
// A predictor pulls the signal field out of each accepted request, scales it and
// truncates the timestamp, then queues the expected result. The result process
// compares every accepted result with the oldest queued one.
// Both sides idle at random, and one test holds the result side off for a long
// stretch so that the pipeline fills and stalls its input.
// time_resolution is written only while nothing is in flight.
module tb_can_signal_extract_scale_core;
    import csx_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_csx_in     i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_csx_out    o_out_data;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    can_signal_extract_scale_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_csx_out    decoded_q[$];
    logic [29:0] time_res;
    int          n_errors;
    int          n_results;
    bit          hold_results;    // long hold on the result side
    bit          steady_results;  // no random stalls on the result side

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Predicted result of one request.
    function automatic t_csx_out decode_signal(t_csx_in req);
        t_csx_out     res;
        logic [5:0]   len;
        logic [6:0]   pos;
        logic [31:0]  raw;
        logic [31:0]  sgn_mask;
        logic signed [64:0] rawv, prod, sum;
        logic signed [64:0] max64, min64;
        len = (req.bit_len > 6'd32) ? 6'd32 : req.bit_len;
        raw = '0;
        pos = {1'b0, req.start_bit};
        for (int i = 0; i < 32; i++) begin
            if (i < len) begin
                if (req.big_endian) begin
                    raw = {raw[30:0], (pos < 64) ? req.payload[pos[5:0]] : 1'b0};
                    if (pos[2:0] == 3'd0) pos = pos + 7'd15;
                    else                  pos = pos - 7'd1;
                end else begin
                    pos = 7'(req.start_bit + i);
                    if (pos < 64) raw[i] = req.payload[pos[5:0]];
                end
            end
        end
        if (req.is_signed && len > 0 && len < 32) begin
            sgn_mask = 32'd1 << (len - 1);
            raw = (raw ^ sgn_mask) - sgn_mask;
        end
        rawv  = req.is_signed ? {{33{raw[31]}}, raw} : {33'd0, raw};
        prod  = rawv * $signed({{33{req.scale[31]}}, req.scale});
        sum   = prod + $signed({{17{req.offset[47]}}, req.offset});
        max64 = {2'b00, {63{1'b1}}};
        min64 = {2'b11, 63'd0};
        res.raw_value = raw;
        res.saturated = 1'b0;
        if (sum > max64) begin
            res.physical_value = max64[63:0];
            res.saturated = 1'b1;
        end else if (sum < min64) begin
            res.physical_value = min64[63:0];
            res.saturated = 1'b1;
        end else begin
            res.physical_value = sum[63:0];
        end
        res.out_sec  = req.ts_sec;
        res.out_nsec = (time_res != 0) ? req.ts_nsec - (req.ts_nsec % time_res)
                                       : req.ts_nsec;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Drive one request and wait for its transfer; valid drops only for a gap.
    task automatic send_request(t_csx_in req, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decoded_q.push_back(decode_signal(req));
    endtask

    // Result side: random stalls, then compare each transfer.
    initial begin
        int wait_n;
        i_out_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_results) begin
                i_out_stall <= 1'b1;
                wait_n = 300;
                repeat (wait_n) @(posedge i_clk);
                hold_results = 1'b0;
            end
            wait_n = steady_results ? 0 : $urandom_range(0, 12);
            if (wait_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected result", 64'd0, 64'd0);
            end else begin
                t_csx_out want;
                want = decoded_q.pop_front();
                if (o_out_data.raw_value !== want.raw_value)
                    report_mismatch("raw_value", o_out_data.raw_value, want.raw_value);
                if (o_out_data.physical_value !== want.physical_value)
                    report_mismatch("physical_value", o_out_data.physical_value,
                                    want.physical_value);
                if (o_out_data.saturated !== want.saturated)
                    report_mismatch("saturated", o_out_data.saturated, want.saturated);
                if (o_out_data.out_sec !== want.out_sec)
                    report_mismatch("out_sec", o_out_data.out_sec, want.out_sec);
                if (o_out_data.out_nsec !== want.out_nsec)
                    report_mismatch("out_nsec", o_out_data.out_nsec, want.out_nsec);
            end
            n_results++;
        end
    end

    // Register write: setup then access cycle; model copy follows.
    task automatic write_time_res(logic [29:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd4 * REG_TIME_RES;
        pwdata  <= {2'b00, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        time_res = value;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
    endtask

    function automatic t_csx_in random_request();
        t_csx_in req;
        req.payload    = {$urandom, $urandom};
        req.start_bit  = 6'($urandom_range(0, 63));
        req.bit_len    = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                        : $urandom_range(1, 32));
        req.big_endian = 1'($urandom);
        req.is_signed  = 1'($urandom);
        req.scale      = $urandom;
        case ($urandom_range(0, 3))
            0: req.offset = 48'({$urandom, $urandom} >> 16);
            1: req.offset = 48'($signed($urandom_range(0, 2000)) - 1000);
            default: req.offset = 48'({$urandom, $urandom});
        endcase
        req.ts_sec  = $urandom;
        req.ts_nsec = 30'(($urandom_range(0, 7) == 0) ? $urandom
                                                      : $urandom_range(0, 999999999));
        return req;
    endfunction

    function automatic t_csx_in plain_request(logic [63:0] data, logic [5:0] start,
                                              logic [5:0] len, logic motorola,
                                              logic sgn);
        t_csx_in req;
        req            = random_request();
        req.payload    = data;
        req.start_bit  = start;
        req.bit_len    = len;
        req.big_endian = motorola;
        req.is_signed  = sgn;
        return req;
    endfunction

    // Field extremes, both byte orders, edge-of-payload and odd lengths.
    task automatic test_directed_fields();
        t_csx_in req;
        send_request(plain_request('1, 0, 32, 0, 0));
        send_request(plain_request('1, 0, 32, 0, 1));
        send_request(plain_request('1, 63, 32, 1, 1));
        send_request(plain_request(64'h8000_0000_0000_0000, 63, 8, 0, 1));  // past byte 7
        send_request(plain_request('1, 7, 32, 1, 0));
        send_request(plain_request('1, 60, 16, 1, 0));   // Motorola off the end
        send_request(plain_request('1, 5, 0, 0, 1));     // zero length
        send_request(plain_request('1, 5, 63, 0, 0));    // length above 32
        send_request(plain_request(64'h0123_4567_89ab_cdef, 12, 1, 1, 1));
        send_request(plain_request(64'h0123_4567_89ab_cdef, 20, 13, 0, 1));
        // positive saturation, large signed products and timestamp extremes
        req = plain_request('1, 0, 32, 0, 0);
        req.scale = 32'h7fff_ffff; req.offset = 48'h7fff_ffff_ffff;
        send_request(req);
        req = plain_request(64'h8000_0000, 0, 32, 0, 1);
        req.scale = 32'h7fff_ffff; req.offset = 48'h8000_0000_0000;
        send_request(req);
        req = plain_request(64'h8000_0000, 0, 32, 0, 1);
        req.scale = 32'h8000_0000; req.offset = 48'h7fff_ffff_ffff;
        send_request(req);
        req = plain_request(64'd0, 0, 32, 0, 0);
        req.scale = 32'd0; req.offset = 48'd0; req.ts_sec = '1; req.ts_nsec = '1;
        send_request(req);
        req.ts_sec = 0; req.ts_nsec = 30'd999999999;
        send_request(req);
        wait_drained();
    endtask

    task automatic test_time_resolution();
        logic [29:0] settings [5] = '{30'd1, 30'd999999999, 30'h3fff_ffff, 30'd1000, 30'd0};
        foreach (settings[k]) begin
            write_time_res(settings[k]);
            for (int i = 0; i < 20; i++) send_request(random_request());
            wait_drained();
        end
    endtask

    // Back-to-back requests while results are held: input must stall.
    task automatic test_backpressure();
        hold_results = 1'b1;
        for (int i = 0; i < 60; i++) begin
            send_request(random_request(), 1'b1);
        end
        steady_results = 1'b1;
        for (int i = 0; i < 60; i++) send_request(random_request(), 1'b1);
        steady_results = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_requests();
        for (int i = 0; i < 520; i++) begin
            if (i % 130 == 0) begin
                wait_drained();
                write_time_res(30'(($urandom_range(0, 5) == 0) ? 0
                                                               : $urandom_range(1, 100000)));
            end
            send_request(random_request(), $urandom_range(0, 3) == 0);
        end
        wait_drained();
    endtask

    initial begin
        int limit;
        n_errors       = 0;
        n_results      = 0;
        hold_results   = 1'b0;
        steady_results = 1'b0;
        time_res       = '0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_fields();
        test_time_resolution();
        test_backpressure();
        test_random_requests();
        limit = 0;
        while (decoded_q.size() != 0 && limit < 100000) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (n_errors == 0 && decoded_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* can_signal_extract_scale_core.f */
src/csx_pkg.sv
src/csx_delay.sv
src/csx_extract.sv
src/csx_arith.sv
src/csx_rem.sv
src/can_signal_extract_scale_core.sv
tb/tb_can_signal_extract_scale_core.sv
